// ===== rtl/lcdt_pkg.sv =====
// lcdt_pkg: shared types and codes for the LCD mode timing block.
// No dependencies; used by the core and the top level.
package lcdt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcdt_mode_t;

  typedef enum logic [2:0] {
    REG_LCD_EN    = 3'd0,
    REG_LINE_CMP  = 3'd1,
    REG_HBLANK_IE = 3'd2,
    REG_VBLANK_IE = 3'd3,
    REG_OAM_IE    = 3'd4,
    REG_MATCH_IE  = 3'd5
  } lcdt_reg_t;

  localparam int CFG_ADDR_W = 5;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic       hblank_ie;
    logic       vblank_ie;
    logic       oam_ie;
    logic       match_ie;
  } lcdt_cfg_t;

  typedef struct packed {
    logic [8:0] dot_counter;
    logic [7:0] line_number;
    lcdt_mode_t mode_now;
    logic       match_flag;
  } lcdt_state_t;

  typedef struct packed {
    lcdt_mode_t lcd_mode;
    logic       coincidence;
    logic [7:0] current_line;
    logic       stat_irq;
    logic       vblank_irq;
    logic       draw_line;
  } lcdt_res_t;

endpackage

// ===== rtl/lcdt_ifs.sv =====
// lcdt_ifs: valid/ready channel interfaces for timing updates and results.
// Depends on nothing; the port widths match the lcdt_pkg types.
interface lcdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink (input valid, input elapsed_cycles, output ready);
endinterface

interface lcdt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic       coincidence;
  logic [7:0] current_line;
  logic       stat_irq;
  logic       vblank_irq;
  logic       draw_line;

  modport source (output valid, output lcd_mode, output coincidence, output current_line,
                  output stat_irq, output vblank_irq, output draw_line, input ready);
  modport sink (input valid, input lcd_mode, input coincidence, input current_line,
                input stat_irq, input vblank_irq, input draw_line, output ready);
endinterface

// ===== rtl/lcdt_core.sv =====
// lcdt_core: combinational status and line step for one timing update.
// Depends on lcdt_pkg for the state, config and result structs.
module lcdt_core
  import lcdt_pkg::*;
#(
  parameter int LINE_CYCLES     = 456,
  parameter int OAM_CYCLES      = 80,
  parameter int TRANSFER_CYCLES = 172,
  parameter int VISIBLE_LINES   = 144,
  parameter int LAST_LINE       = 153
) (
  input  lcdt_cfg_t   cfg,
  input  lcdt_state_t state,
  input  logic [7:0]  elapsed_cycles,
  output lcdt_state_t state_nxt,
  output lcdt_res_t   res
);

  localparam logic signed [10:0] UPPER_S = 11'(LINE_CYCLES - OAM_CYCLES);
  localparam logic signed [10:0] LOWER_S = 11'(LINE_CYCLES - OAM_CYCLES - TRANSFER_CYCLES);
  localparam logic [8:0] LINE_CNT = 9'(LINE_CYCLES);
  localparam logic [8:0] VIS_N    = 9'(VISIBLE_LINES);
  localparam logic [8:0] LAST_N   = 9'(LAST_LINE);

  logic signed [10:0] cnt_s;
  lcdt_mode_t         mode;
  logic               req;
  logic               match;
  logic               run_out;
  logic [8:0]         next_line;

  always_comb begin
    cnt_s     = $signed({2'b00, state.dot_counter});
    mode      = MODE_HBLANK;
    req       = 1'b0;
    match     = (state.line_number == cfg.line_compare);
    run_out   = ({1'b0, elapsed_cycles} >= state.dot_counter);
    next_line = {1'b0, state.line_number} + 9'd1;
    state_nxt = state;
    res       = '0;

    if (!cfg.lcd_enable) begin
      state_nxt.dot_counter = LINE_CNT;
      state_nxt.mode_now    = MODE_VBLANK;
      state_nxt.line_number = '0;
      res.lcd_mode          = MODE_VBLANK;
      res.coincidence       = state.match_flag;
      res.current_line      = '0;
    end else begin
      if ({1'b0, state.line_number} >= VIS_N) begin
        mode = MODE_VBLANK;
        req  = cfg.vblank_ie;
      end else if (cnt_s >= UPPER_S) begin
        mode = MODE_OAM;
        req  = cfg.oam_ie;
      end else if (cnt_s >= LOWER_S) begin
        mode = MODE_XFER;
      end else begin
        mode = MODE_HBLANK;
        req  = cfg.hblank_ie;
      end

      state_nxt.mode_now   = mode;
      state_nxt.match_flag = match;
      res.lcd_mode         = mode;
      res.coincidence      = match;
      res.stat_irq         = (req && (mode != state.mode_now)) || (match && cfg.match_ie);

      if (run_out) begin
        state_nxt.dot_counter = LINE_CNT;
        if (next_line == VIS_N) begin
          res.vblank_irq = 1'b1;
        end else if (next_line > LAST_N) begin
          next_line = '0;
        end else if (next_line < VIS_N) begin
          res.draw_line = 1'b1;
        end
        state_nxt.line_number = next_line[7:0];
      end else begin
        state_nxt.dot_counter = state.dot_counter - {1'b0, elapsed_cycles};
      end
      res.current_line = state_nxt.line_number;
    end
  end

endmodule

// ===== rtl/lcd_mode_timing_top.sv =====
// lcd_mode_timing_top: LCD mode timing controller with APB-style config port.
// Result: registered; valid in the cycle after the update transaction is accepted.
// Throughput: one transaction per cycle; in ready whenever the result register is
// empty or being drained in the same cycle.
// Reset (rst_n, synchronous): timing state, config registers and result valid cleared.
// Depends on lcdt_pkg, lcdt_ifs and lcdt_core.
module lcd_mode_timing_top
  import lcdt_pkg::*;
#(
  parameter int LINE_CYCLES     = 456,
  parameter int OAM_CYCLES      = 80,
  parameter int TRANSFER_CYCLES = 172,
  parameter int VISIBLE_LINES   = 144,
  parameter int LAST_LINE       = 153
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lcdt_in_if.sink               in_chan,
  lcdt_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  lcdt_cfg_t   cfg_r;
  lcdt_state_t state_r;
  lcdt_state_t state_nxt;
  lcdt_res_t   res_r;
  lcdt_res_t   res_nxt;
  logic        out_valid_r;
  logic        in_fire;
  logic        cfg_wr;
  lcdt_reg_t   reg_sel;

  assign pready          = 1'b1;
  assign cfg_wr          = psel && penable && pwrite;
  assign reg_sel         = lcdt_reg_t'(paddr[4:2]);
  assign in_chan.ready   = !out_valid_r || out_chan.ready;
  assign in_fire         = in_chan.valid && in_chan.ready;

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_LCD_EN:    prdata[0]   = cfg_r.lcd_enable;
      REG_LINE_CMP:  prdata[7:0] = cfg_r.line_compare;
      REG_HBLANK_IE: prdata[0]   = cfg_r.hblank_ie;
      REG_VBLANK_IE: prdata[0]   = cfg_r.vblank_ie;
      REG_OAM_IE:    prdata[0]   = cfg_r.oam_ie;
      REG_MATCH_IE:  prdata[0]   = cfg_r.match_ie;
      default:       prdata      = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LCD_EN:    cfg_r.lcd_enable   <= pwdata[0];
        REG_LINE_CMP:  cfg_r.line_compare <= pwdata[7:0];
        REG_HBLANK_IE: cfg_r.hblank_ie    <= pwdata[0];
        REG_VBLANK_IE: cfg_r.vblank_ie    <= pwdata[0];
        REG_OAM_IE:    cfg_r.oam_ie       <= pwdata[0];
        REG_MATCH_IE:  cfg_r.match_ie     <= pwdata[0];
        default: ;
      endcase
    end
  end

  lcdt_core #(
    .LINE_CYCLES     (LINE_CYCLES),
    .OAM_CYCLES      (OAM_CYCLES),
    .TRANSFER_CYCLES (TRANSFER_CYCLES),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .LAST_LINE       (LAST_LINE)
  ) u_core (
    .cfg            (cfg_r),
    .state          (state_r),
    .elapsed_cycles (in_chan.elapsed_cycles),
    .state_nxt      (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.lcd_mode     = res_r.lcd_mode;
  assign out_chan.coincidence  = res_r.coincidence;
  assign out_chan.current_line = res_r.current_line;
  assign out_chan.stat_irq     = res_r.stat_irq;
  assign out_chan.vblank_irq   = res_r.vblank_irq;
  assign out_chan.draw_line    = res_r.draw_line;

endmodule

// ===== rtl/lcdt_checker.sv =====
// lcdt_checker: port-level assertions for lcd_mode_timing_top, attached by bind.
// Depends on lcd_mode_timing_top port names and parameters.
module lcdt_checker #(
  parameter int VISIBLE_LINES = 144
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] current_line,
  input logic       vblank_irq,
  input logic       draw_line
);

  localparam logic [7:0] VIS_L = 8'(VISIBLE_LINES);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && vblank_irq |-> (current_line == VIS_L) && !draw_line)
    else $error("vblank strobe off line");

  a_draw_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && draw_line |-> (current_line != 8'd0) && (current_line < VIS_L))
    else $error("draw strobe on invisible line");

endmodule

bind lcd_mode_timing_top lcdt_checker #(
  .VISIBLE_LINES (VISIBLE_LINES)
) u_lcdt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .current_line (out_chan.current_line),
  .vblank_irq   (out_chan.vblank_irq),
  .draw_line    (out_chan.draw_line)
);
